/* sv/ppcd_pkg.sv */
// Shared types, codes and sizes of the pin pair change detector.
// Used by ppcd_tables, ppcd_match and pin_pair_change_detector; no dependencies.
package ppcd_pkg;

  // Number of entries in each pair table (1 to 16)
  localparam int PAIR_SLOTS = 16;
  localparam int SLOT_AW    = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
  localparam int CNT_W      = $clog2(PAIR_SLOTS + 1);

  localparam logic [7:0] EMPTY_PIN = 8'hFF;

  // Command codes on the input tuser
  localparam logic [2:0] CMD_WR_CUR   = 3'd0;
  localparam logic [2:0] CMD_WR_SNAP  = 3'd1;
  localparam logic [2:0] CMD_ADVANCE  = 3'd2;
  localparam logic [2:0] CMD_REPORT   = 3'd3;
  localparam logic [2:0] CMD_CLR_CUR  = 3'd4;
  localparam logic [2:0] CMD_CLR_SNAP = 3'd5;

  // Event kinds on the output tuser
  localparam logic [1:0] EV_CONNECT    = 2'd0;
  localparam logic [1:0] EV_DISCONNECT = 2'd1;
  localparam logic [1:0] EV_DONE       = 2'd2;

  typedef struct packed {
    logic [7:0] pin_b;
    logic [7:0] pin_a;
  } pair_t;

  // Table update operations
  typedef enum logic [2:0] {
    TOP_NONE,
    TOP_WR_CUR,
    TOP_WR_SNAP,
    TOP_ADVANCE,
    TOP_CLR_CUR,
    TOP_CLR_SNAP,
    TOP_KILL_SNAP
  } tbl_op_e;

  typedef struct packed {
    tbl_op_e              op;
    logic [SLOT_AW-1:0]   addr;
    pair_t                pair;
  } tbl_req_t;

  // Outcome of the shared compare unit
  typedef struct packed {
    logic cur_used;
    logic same_pair;
    logic snap_stale;
  } match_t;

endpackage

/* sv/pin_pair_change_detector.sv */
// Top level of the pin pair change detector: command sequencer and output register.
// Depends on ppcd_pkg, ppcd_tables and ppcd_match.
//
// Usage: one command word enters on the s_axis channel; tuser carries the
// command, tdata the entry index and the pin pair. Table writes, advance and
// clears take effect at the edge that accepts the word and produce nothing.
// A report walks the current table one entry a cycle; each used entry then
// searches the snapshot one entry a cycle through a single shared compare
// unit, and a search ends early on a match. A second pass scans the snapshot
// one entry a cycle while no result waits on a stalled receiver. Result words
// leave on m_axis: tuser is the event kind, tdata the pins, tlast marks the
// closing done word. A report keeps the input not ready from the accepting
// edge until the done word enters the output register; every other command
// leaves the input ready. Results sit in one output register; when the
// receiver stalls, either walk holds until that register frees up. Reset
// empties both tables and drops any report in progress.
module pin_pair_change_detector (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // entry_index[3:0], pin_a[11:4], pin_b[19:12]
  input  logic [2:0]  s_axis_tuser,  // command[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // event_pin_a[7:0], event_pin_b[15:8]
  output logic [1:0]  m_axis_tuser,  // event_kind[1:0]
  output logic        m_axis_tlast   // last_of_run
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CUR  = 3'd1;
  localparam logic [2:0] ST_SRCH = 3'd2;
  localparam logic [2:0] ST_CONN = 3'd3;
  localparam logic [2:0] ST_SNAP = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [ppcd_pkg::CNT_W-1:0] LAST_CNT = ppcd_pkg::CNT_W'(ppcd_pkg::PAIR_SLOTS);

  logic [2:0]                 state_q, state_d;
  logic [ppcd_pkg::CNT_W-1:0] cur_idx_q, cur_idx_d;
  logic [ppcd_pkg::CNT_W-1:0] snap_idx_q, snap_idx_d;

  logic       out_valid_q, out_valid_d;
  logic [1:0] out_kind_q, out_kind_d;
  logic [7:0] out_a_q, out_a_d;
  logic [7:0] out_b_q, out_b_d;
  logic       out_last_q, out_last_d;

  logic              in_accept;
  logic              out_free;
  logic [2:0]        in_cmd;
  logic [3:0]        in_index;
  ppcd_pkg::pair_t   in_pair;
  logic              in_index_ok;
  ppcd_pkg::tbl_req_t tbl_req;
  ppcd_pkg::pair_t   cur_pair;
  ppcd_pkg::pair_t   snap_pair;
  ppcd_pkg::match_t  match;

  assign in_cmd        = s_axis_tuser;
  assign in_index      = s_axis_tdata[3:0];
  assign in_pair.pin_a = s_axis_tdata[11:4];
  assign in_pair.pin_b = s_axis_tdata[19:12];
  assign in_index_ok   = 32'(in_index) < ppcd_pkg::PAIR_SLOTS;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  ppcd_tables u_tables (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (tbl_req),
    .cur_addr_i (cur_idx_q[ppcd_pkg::SLOT_AW-1:0]),
    .snap_addr_i(snap_idx_q[ppcd_pkg::SLOT_AW-1:0]),
    .cur_pair_o (cur_pair),
    .snap_pair_o(snap_pair)
  );

  ppcd_match u_match (
    .cur_i (cur_pair),
    .snap_i(snap_pair),
    .res_o (match)
  );

  // Sequencer: decode commands, walk the tables, feed the output register
  always_comb begin
    state_d      = state_q;
    cur_idx_d    = cur_idx_q;
    snap_idx_d   = snap_idx_q;
    tbl_req.op   = ppcd_pkg::TOP_NONE;
    tbl_req.addr = ppcd_pkg::SLOT_AW'(in_index);
    tbl_req.pair = in_pair;

    out_valid_d = out_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_a_d     = out_a_q;
    out_b_d     = out_b_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            ppcd_pkg::CMD_WR_CUR: begin
              if (in_index_ok) tbl_req.op = ppcd_pkg::TOP_WR_CUR;
            end
            ppcd_pkg::CMD_WR_SNAP: begin
              if (in_index_ok) tbl_req.op = ppcd_pkg::TOP_WR_SNAP;
            end
            ppcd_pkg::CMD_ADVANCE:  tbl_req.op = ppcd_pkg::TOP_ADVANCE;
            ppcd_pkg::CMD_CLR_CUR:  tbl_req.op = ppcd_pkg::TOP_CLR_CUR;
            ppcd_pkg::CMD_CLR_SNAP: tbl_req.op = ppcd_pkg::TOP_CLR_SNAP;
            ppcd_pkg::CMD_REPORT: begin
              cur_idx_d = '0;
              state_d   = ST_CUR;
            end
            default: ;
          endcase
        end
      end
      // Pick the next used current entry
      ST_CUR: begin
        if (cur_idx_q == LAST_CNT) begin
          snap_idx_d = '0;
          state_d    = ST_SNAP;
        end else if (match.cur_used) begin
          snap_idx_d = '0;
          state_d    = ST_SRCH;
        end else begin
          cur_idx_d = cur_idx_q + 1'b1;
        end
      end
      // Search the snapshot for the same unordered pair
      ST_SRCH: begin
        if (snap_idx_q == LAST_CNT) begin
          state_d = ST_CONN;
        end else if (match.same_pair) begin
          tbl_req.op   = ppcd_pkg::TOP_KILL_SNAP;
          tbl_req.addr = snap_idx_q[ppcd_pkg::SLOT_AW-1:0];
          cur_idx_d    = cur_idx_q + 1'b1;
          state_d      = ST_CUR;
        end else begin
          snap_idx_d = snap_idx_q + 1'b1;
        end
      end
      // Emit a connected word for an unmatched current pair
      ST_CONN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = ppcd_pkg::EV_CONNECT;
          out_a_d     = cur_pair.pin_a;
          out_b_d     = cur_pair.pin_b;
          out_last_d  = 1'b0;
          cur_idx_d   = cur_idx_q + 1'b1;
          state_d     = ST_CUR;
        end
      end
      // Emit a disconnected word for each leftover snapshot pair
      ST_SNAP: begin
        if (snap_idx_q == LAST_CNT) begin
          state_d = ST_DONE;
        end else if (!match.snap_stale) begin
          snap_idx_d = snap_idx_q + 1'b1;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = ppcd_pkg::EV_DISCONNECT;
          out_a_d     = snap_pair.pin_a;
          out_b_d     = snap_pair.pin_b;
          out_last_d  = 1'b0;
          snap_idx_d  = snap_idx_q + 1'b1;
        end
      end
      // Close the report
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_kind_d  = ppcd_pkg::EV_DONE;
          out_a_d     = '0;
          out_b_d     = '0;
          out_last_d  = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_idx_q   <= '0;
      snap_idx_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_idx_q   <= cur_idx_d;
      snap_idx_q  <= snap_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_a_q    <= out_a_d;
    out_b_q    <= out_b_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_b_q, out_a_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  // A stalled result word holds until the receiver takes it
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) &&
      $stable(m_axis_tuser) && $stable(m_axis_tlast)))
    else $error("result word changed while stalled");

  // Only the done word carries tlast
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tuser == ppcd_pkg::EV_DONE) == m_axis_tlast))
    else $error("done kind and tlast disagree");

  // A search only runs for a used current entry
  a_search_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) |-> match.cur_used)
    else $error("snapshot search on an empty current entry");

  // Walk counters never run past the table end
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_idx_q <= LAST_CNT) && (snap_idx_q <= LAST_CNT))
    else $error("table walk index out of range");

endmodule

/* sv/ppcd_tables.sv */
// Current and snapshot pair tables held in flops, with one read port each.
// Depends on ppcd_pkg.
module ppcd_tables (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ppcd_pkg::tbl_req_t           req_i,
  input  logic [ppcd_pkg::SLOT_AW-1:0] cur_addr_i,
  input  logic [ppcd_pkg::SLOT_AW-1:0] snap_addr_i,
  output ppcd_pkg::pair_t              cur_pair_o,
  output ppcd_pkg::pair_t              snap_pair_o
);

  localparam ppcd_pkg::pair_t EMPTY_PAIR = '{pin_b: ppcd_pkg::EMPTY_PIN,
                                             pin_a: ppcd_pkg::EMPTY_PIN};

  ppcd_pkg::pair_t cur_q  [ppcd_pkg::PAIR_SLOTS];
  ppcd_pkg::pair_t snap_q [ppcd_pkg::PAIR_SLOTS];

  // Read ports; an address past the last entry reads as empty
  always_comb begin
    cur_pair_o  = EMPTY_PAIR;
    snap_pair_o = EMPTY_PAIR;
    if (32'(cur_addr_i) < ppcd_pkg::PAIR_SLOTS) begin
      cur_pair_o = cur_q[cur_addr_i];
    end
    if (32'(snap_addr_i) < ppcd_pkg::PAIR_SLOTS) begin
      snap_pair_o = snap_q[snap_addr_i];
    end
  end

  // Apply one table operation per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ppcd_pkg::PAIR_SLOTS; k++) begin
        cur_q[k]  <= EMPTY_PAIR;
        snap_q[k] <= EMPTY_PAIR;
      end
    end else begin
      for (int k = 0; k < ppcd_pkg::PAIR_SLOTS; k++) begin
        case (req_i.op)
          ppcd_pkg::TOP_WR_CUR: begin
            if (req_i.addr == ppcd_pkg::SLOT_AW'(k)) cur_q[k] <= req_i.pair;
          end
          ppcd_pkg::TOP_WR_SNAP: begin
            if (req_i.addr == ppcd_pkg::SLOT_AW'(k)) snap_q[k] <= req_i.pair;
          end
          ppcd_pkg::TOP_KILL_SNAP: begin
            if (req_i.addr == ppcd_pkg::SLOT_AW'(k)) snap_q[k] <= EMPTY_PAIR;
          end
          ppcd_pkg::TOP_ADVANCE: begin
            snap_q[k] <= cur_q[k];
            cur_q[k]  <= EMPTY_PAIR;
          end
          ppcd_pkg::TOP_CLR_CUR:  cur_q[k]  <= EMPTY_PAIR;
          ppcd_pkg::TOP_CLR_SNAP: snap_q[k] <= EMPTY_PAIR;
          default: ;
        endcase
      end
    end
  end

endmodule

/* sv/ppcd_match.sv */
// Shared pair compare unit used by the current walk, the snapshot search and the snapshot pass.
// Depends on ppcd_pkg.
module ppcd_match (
  input  ppcd_pkg::pair_t  cur_i,
  input  ppcd_pkg::pair_t  snap_i,
  output ppcd_pkg::match_t res_o
);

  // Unordered pair equality plus the two entry predicates
  always_comb begin
    res_o.cur_used   = (cur_i.pin_a != ppcd_pkg::EMPTY_PIN) &&
                       (cur_i.pin_b != ppcd_pkg::EMPTY_PIN);
    res_o.same_pair  = ((snap_i.pin_a == cur_i.pin_a) && (snap_i.pin_b == cur_i.pin_b)) ||
                       ((snap_i.pin_a == cur_i.pin_b) && (snap_i.pin_b == cur_i.pin_a));
    res_o.snap_stale = (snap_i.pin_a != snap_i.pin_b) &&
                       (snap_i.pin_b != ppcd_pkg::EMPTY_PIN);
  end

endmodule
